FILE: rtl/core/tlt_pkg.sv
// Shared constants and register indexes for the tensor layout transpose addresser.
package tlt_pkg;

    // Fixed field widths
    localparam int ADDR_W        = 44;
    localparam int ELEM_W        = 32;
    localparam int COUNT_W       = 13;
    localparam int BATCH_COUNT_W = 9;
    localparam int OUT_TDATA_W   = 80;   // address + bits, padded to whole bytes

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCUMULATE_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH_COUNT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT    = 3'd5;

    // Accumulate mode code that requests add-into-destination
    localparam logic ADD_TO = 1'b1;

    // Parameter defaults
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int DIM_BITS_DEF     = 12;
    localparam int BATCH_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF  = 4;

endpackage

FILE: rtl/core/tensor_layout_transpose_addresser.sv
// Top level of the NCHW/NHWC tensor layout transpose addresser.
//
// Feed the tensor one element per transfer in source layout order; each element comes
// back with its element index in the other layout (direction 0: NCHW to NHWC,
// 1: NHWC to NCHW), its bits masked to ELEMENT_BITS, the add-to flag on tuser and
// tlast on the tensor's final element, after which the position counters wrap to
// zero. The block takes one element per clock and returns one result per clock
// while the result side is ready; an element passes through the input queue and
// then the three multiply-add stages that build the address, the last of which is
// the output register. The queue of QUEUE_DEPTH entries between the counters and
// the address stages lets the input keep flowing while the output stalls, until
// the queue is full. Write the registers only while the block is idle; writes
// never touch the counters.
module tensor_layout_transpose_addresser #(
    parameter int ELEMENT_BITS = tlt_pkg::ELEMENT_BITS_DEF,
    parameter int DIM_BITS     = tlt_pkg::DIM_BITS_DEF,
    parameter int BATCH_BITS   = tlt_pkg::BATCH_BITS_DEF,
    parameter int QUEUE_DEPTH  = tlt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tlt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tlt_pkg::ELEM_W-1:0]       s_tdata,   // [31:0] element_bits
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tlt_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [43:0] dest_address, [75:44] dest_bits
    output logic                             m_tuser,   // [0] accumulate
    output logic                             m_tlast
);
    import tlt_pkg::*;

    localparam int ENTRY_W = BATCH_BITS + 3 * COUNT_W + 3 * DIM_BITS + ELEM_W + 2;

    logic q_full, q_push, q_pop, q_valid;
    logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

    logic [BATCH_BITS-1:0] f_batch,  b_batch;
    logic [COUNT_W-1:0]    f_k1, f_k2, f_k3, b_k1, b_k2, b_k3;
    logic [DIM_BITS-1:0]   f_p1, f_p2, f_p3, b_p1, b_p2, b_p3;
    logic [ELEM_W-1:0]     f_bits, b_bits;
    logic                  f_acc, f_last, b_acc, b_last;

    tlt_front #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .DIM_BITS     (DIM_BITS),
        .BATCH_BITS   (BATCH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .op_batch      (f_batch),
        .op_k1         (f_k1),
        .op_k2         (f_k2),
        .op_k3         (f_k3),
        .op_p1         (f_p1),
        .op_p2         (f_p2),
        .op_p3         (f_p3),
        .op_bits       (f_bits),
        .op_accumulate (f_acc),
        .op_last       (f_last)
    );

    // Pack and unpack queue entries
    assign q_wr_data = {f_last, f_acc, f_bits, f_p3, f_p2, f_p1, f_k3, f_k2, f_k1, f_batch};
    assign {b_last, b_acc, b_bits, b_p3, b_p2, b_p1, b_k3, b_k2, b_k1, b_batch} = q_rd_data;

    tlt_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    tlt_back #(
        .DIM_BITS   (DIM_BITS),
        .BATCH_BITS (BATCH_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .op_batch      (b_batch),
        .op_k1         (b_k1),
        .op_k2         (b_k2),
        .op_k3         (b_k3),
        .op_p1         (b_p1),
        .op_p2         (b_p2),
        .op_p3         (b_p3),
        .op_bits       (b_bits),
        .op_accumulate (b_acc),
        .op_last       (b_last),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

FILE: rtl/core/tlt_front.sv
// Front end: configuration registers, position counters and address operand selection.
module tlt_front #(
    parameter int ELEMENT_BITS = tlt_pkg::ELEMENT_BITS_DEF,
    parameter int DIM_BITS     = tlt_pkg::DIM_BITS_DEF,
    parameter int BATCH_BITS   = tlt_pkg::BATCH_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tlt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tlt_pkg::ELEM_W-1:0]       s_tdata,    // [31:0] element_bits
    input  logic                             q_full,
    output logic                             q_push,
    output logic [BATCH_BITS-1:0]            op_batch,
    output logic [tlt_pkg::COUNT_W-1:0]      op_k1,
    output logic [tlt_pkg::COUNT_W-1:0]      op_k2,
    output logic [tlt_pkg::COUNT_W-1:0]      op_k3,
    output logic [DIM_BITS-1:0]              op_p1,
    output logic [DIM_BITS-1:0]              op_p2,
    output logic [DIM_BITS-1:0]              op_p3,
    output logic [tlt_pkg::ELEM_W-1:0]       op_bits,
    output logic                             op_accumulate,
    output logic                             op_last
);
    import tlt_pkg::*;

    localparam int unsigned DIM_MAX   = 32'd1 << DIM_BITS;
    localparam int unsigned BATCH_MAX = 32'd1 << BATCH_BITS;
    localparam logic [63:0] ELEM_MASK64 =
        (ELEMENT_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ELEMENT_BITS) - 64'd1);
    localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_MASK64[ELEM_W-1:0];

    // Zero acts as one, oversized counts clamp to the counter range
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] raw,
                                                     input int unsigned max_count);
        logic [COUNT_W-1:0] r;
        if (raw == '0) begin
            r = COUNT_W'(1);
        end else if (32'(raw) > max_count) begin
            r = COUNT_W'(max_count);
        end else begin
            r = raw;
        end
        return r;
    endfunction

    logic                     direction_reg;
    logic                     accumulate_mode_reg;
    logic [BATCH_COUNT_W-1:0] batch_count_reg;
    logic [COUNT_W-1:0]       channel_count_reg;
    logic [COUNT_W-1:0]       row_count_reg;
    logic [COUNT_W-1:0]       column_count_reg;

    logic [BATCH_BITS-1:0] batch_pos_reg,  batch_pos_next;
    logic [DIM_BITS-1:0]   outer_pos_reg,  outer_pos_next;
    logic [DIM_BITS-1:0]   middle_pos_reg, middle_pos_next;
    logic [DIM_BITS-1:0]   inner_pos_reg,  inner_pos_next;

    logic [COUNT_W-1:0] nb, nc, nh, nw;
    logic [COUNT_W-1:0] outer_n, middle_n, inner_n;
    logic batch_end, outer_end, middle_end, inner_end, last;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg       <= 1'b0;
            accumulate_mode_reg <= 1'b0;
            batch_count_reg     <= BATCH_COUNT_W'(1);
            channel_count_reg   <= COUNT_W'(1);
            row_count_reg       <= COUNT_W'(1);
            column_count_reg    <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIRECTION:       direction_reg       <= cfg_wdata[0];
                REG_ACCUMULATE_MODE: accumulate_mode_reg <= cfg_wdata[0];
                REG_BATCH_COUNT:     batch_count_reg     <= cfg_wdata[BATCH_COUNT_W-1:0];
                REG_CHANNEL_COUNT:   channel_count_reg   <= cfg_wdata;
                REG_ROW_COUNT:       row_count_reg       <= cfg_wdata;
                REG_COLUMN_COUNT:    column_count_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective counts and per-direction loop order
    always_comb begin
        nb = eff_count(COUNT_W'(batch_count_reg), BATCH_MAX);
        nc = eff_count(channel_count_reg, DIM_MAX);
        nh = eff_count(row_count_reg, DIM_MAX);
        nw = eff_count(column_count_reg, DIM_MAX);
        if (direction_reg) begin
            outer_n = nh; middle_n = nw; inner_n = nc;
        end else begin
            outer_n = nc; middle_n = nh; inner_n = nw;
        end
    end

    // A counter at or beyond its last index wraps on its next advance
    assign batch_end  = (32'(batch_pos_reg)  + 32'd1) >= 32'(nb);
    assign outer_end  = (32'(outer_pos_reg)  + 32'd1) >= 32'(outer_n);
    assign middle_end = (32'(middle_pos_reg) + 32'd1) >= 32'(middle_n);
    assign inner_end  = (32'(inner_pos_reg)  + 32'd1) >= 32'(inner_n);
    assign last       = batch_end && outer_end && middle_end && inner_end;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Advance the nested counters; clear all after the final element
    always_comb begin
        inner_pos_next  = inner_pos_reg;
        middle_pos_next = middle_pos_reg;
        outer_pos_next  = outer_pos_reg;
        batch_pos_next  = batch_pos_reg;
        if (q_push) begin
            inner_pos_next = inner_end ? '0 : inner_pos_reg + 1'b1;
            if (inner_end) begin
                middle_pos_next = middle_end ? '0 : middle_pos_reg + 1'b1;
                if (middle_end) begin
                    outer_pos_next = outer_end ? '0 : outer_pos_reg + 1'b1;
                    if (outer_end) begin
                        batch_pos_next = batch_end ? '0 : batch_pos_reg + 1'b1;
                    end
                end
            end
            if (last) begin
                inner_pos_next  = '0;
                middle_pos_next = '0;
                outer_pos_next  = '0;
                batch_pos_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_pos_reg  <= '0;
            outer_pos_reg  <= '0;
            middle_pos_reg <= '0;
            inner_pos_reg  <= '0;
        end else begin
            batch_pos_reg  <= batch_pos_next;
            outer_pos_reg  <= outer_pos_next;
            middle_pos_reg <= middle_pos_next;
            inner_pos_reg  <= inner_pos_next;
        end
    end

    // Map positions onto the multiply-add chain of the destination layout
    always_comb begin
        op_batch = batch_pos_reg;
        if (direction_reg) begin
            op_k1 = nc; op_p1 = inner_pos_reg;
            op_k2 = nh; op_p2 = outer_pos_reg;
            op_k3 = nw; op_p3 = middle_pos_reg;
        end else begin
            op_k1 = nh; op_p1 = middle_pos_reg;
            op_k2 = nw; op_p2 = inner_pos_reg;
            op_k3 = nc; op_p3 = outer_pos_reg;
        end
        op_bits       = s_tdata & ELEM_MASK;
        op_accumulate = (accumulate_mode_reg == ADD_TO);
        op_last       = last;
    end

    property p_last_clears;
        @(posedge aclk) disable iff (!aresetn)
            q_push && last |=> (batch_pos_reg == '0) && (outer_pos_reg == '0) &&
                               (middle_pos_reg == '0) && (inner_pos_reg == '0);
    endproperty
    a_last_clears: assert property (p_last_clears)
        else $error("counters not cleared after final element");

    property p_hold_without_transfer;
        @(posedge aclk) disable iff (!aresetn)
            !q_push |=> $stable(inner_pos_reg) && $stable(batch_pos_reg);
    endproperty
    a_hold_without_transfer: assert property (p_hold_without_transfer)
        else $error("position moved without an input transfer");

endmodule

FILE: rtl/core/tlt_queue.sv
// Short FIFO between the front end and the address pipeline.
module tlt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tlt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);
    import tlt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    // Store incoming entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) push |-> !full;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue written while full");

endmodule

FILE: rtl/core/tlt_back.sv
// Back end: three multiply-add stages that form the destination address, with output register.
module tlt_back #(
    parameter int DIM_BITS   = tlt_pkg::DIM_BITS_DEF,
    parameter int BATCH_BITS = tlt_pkg::BATCH_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  logic [BATCH_BITS-1:0]             op_batch,
    input  logic [tlt_pkg::COUNT_W-1:0]       op_k1,
    input  logic [tlt_pkg::COUNT_W-1:0]       op_k2,
    input  logic [tlt_pkg::COUNT_W-1:0]       op_k3,
    input  logic [DIM_BITS-1:0]               op_p1,
    input  logic [DIM_BITS-1:0]               op_p2,
    input  logic [DIM_BITS-1:0]               op_p3,
    input  logic [tlt_pkg::ELEM_W-1:0]        op_bits,
    input  logic                              op_accumulate,
    input  logic                              op_last,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tlt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [43:0] dest_address, [75:44] dest_bits
    output logic                              m_tuser,   // [0] accumulate
    output logic                              m_tlast
);
    import tlt_pkg::*;

    logic adv;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [COUNT_W-1:0] s1_k2_reg, s1_k3_reg;
    logic [DIM_BITS-1:0] s1_p2_reg, s1_p3_reg;
    logic [ELEM_W-1:0] s1_bits_reg;
    logic              s1_acc_reg, s1_last_reg;

    logic              s2_valid_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [COUNT_W-1:0] s2_k3_reg;
    logic [DIM_BITS-1:0] s2_p3_reg;
    logic [ELEM_W-1:0] s2_bits_reg;
    logic              s2_acc_reg, s2_last_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [ELEM_W-1:0] out_bits_reg;
    logic              out_acc_reg, out_last_reg;

    // Whole pipeline moves when the output register is free or being taken
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_valid;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Multiply-add chain, modulo the address width
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_addr_reg  <= ADDR_W'(op_batch) * ADDR_W'(op_k1) + ADDR_W'(op_p1);
            s1_k2_reg    <= op_k2;
            s1_k3_reg    <= op_k3;
            s1_p2_reg    <= op_p2;
            s1_p3_reg    <= op_p3;
            s1_bits_reg  <= op_bits;
            s1_acc_reg   <= op_accumulate;
            s1_last_reg  <= op_last;

            s2_addr_reg  <= s1_addr_reg * ADDR_W'(s1_k2_reg) + ADDR_W'(s1_p2_reg);
            s2_k3_reg    <= s1_k3_reg;
            s2_p3_reg    <= s1_p3_reg;
            s2_bits_reg  <= s1_bits_reg;
            s2_acc_reg   <= s1_acc_reg;
            s2_last_reg  <= s1_last_reg;

            out_addr_reg <= s2_addr_reg * ADDR_W'(s2_k3_reg) + ADDR_W'(s2_p3_reg);
            out_bits_reg <= s2_bits_reg;
            out_acc_reg  <= s2_acc_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ADDR_W - ELEM_W){1'b0}}, out_bits_reg, out_addr_reg};
    assign m_tuser  = out_acc_reg;
    assign m_tlast  = out_last_reg;

    property p_stage_reaches_output;
        @(posedge aclk) disable iff (!aresetn) s2_valid_reg && adv |=> out_valid_reg;
    endproperty
    a_stage_reaches_output: assert property (p_stage_reaches_output)
        else $error("pipeline entry lost before output register");

endmodule
